### hdl/ncs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_pkg: shared definitions for the nearest configuration search block
// Sizes, field widths, codes, state encoding and controller/datapath
// interface structs.
// ----------------------------------------------------------------------------
package ncs_pkg;

	// Store geometry and angle precision
	localparam int MAX_POINTS = 1024;
	localparam int JOINTS     = 16;
	localparam int ANGLE_BITS = 16;

	// Fixed field widths of the stream payloads
	localparam int IN_ANGLE_BITS = 16;
	localparam int INDEX_BITS    = 10;
	localparam int DIST_BITS     = 36;
	localparam int S_DATA_BITS   = 16;
	localparam int M_DATA_BITS   = 48;

	// Derived widths
	localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int PW  = $clog2(JOINTS + 1);
	localparam int IW  = $clog2(MAX_POINTS);
	localparam int CW  = $clog2(MAX_POINTS + 1);
	localparam int AW  = $clog2(MAX_POINTS * JOINTS);
	localparam int SQW = 2 * ANGLE_BITS + 2;
	localparam int SUMW = (SQW + 1 > DIST_BITS + 1) ? SQW + 1 : DIST_BITS + 1;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	// Codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_COPY,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} ncs_state_t;

	typedef struct packed {
		logic take;
		logic copy;
		logic scan;
		logic emit;
	} ncs_cmd_t;

	typedef struct packed {
		logic store_full;
		logic store_empty;
		logic copy_last;
		logic scan_last;
		logic scan_done;
		logic out_free;
	} ncs_status_t;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;

	// Keep the low ANGLE_BITS bits when narrower, sign-extend when wider
	function automatic angle_t to_angle(input logic [IN_ANGLE_BITS-1:0] raw);
		return angle_t'(signed'(raw));
	endfunction

endpackage
`default_nettype wire

### hdl/ncs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ncs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hdl/ncs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_ctrl: sequencing state machine
// Collect joints, then copy a point into the store or scan the store, or
// neither when full or empty, then hand the result to the output register.
// ----------------------------------------------------------------------------
module ncs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tlast,
	input  wire logic                s_tuser,
	output logic                     s_tready,
	input  wire ncs_pkg::ncs_status_t status,
	output ncs_pkg::ncs_cmd_t        cmd
);
	import ncs_pkg::*;

	ncs_state_t state_q;
	ncs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_COLLECT: begin
				if (s_tvalid && s_tlast) begin
					if (s_tuser == FUNC_INSERT) begin
						state_d = status.store_full ? ST_EMIT : ST_COPY;
					end else begin
						state_d = status.store_empty ? ST_EMIT : ST_SCAN;
					end
				end
			end
			ST_COPY: begin
				if (status.copy_last) state_d = ST_EMIT;
			end
			ST_SCAN: begin
				if (status.scan_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_d = ST_COLLECT;
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_COLLECT);
		cmd.take = s_tvalid && (state_q == ST_COLLECT);
		cmd.copy = (state_q == ST_COPY);
		cmd.scan = (state_q == ST_SCAN);
		cmd.emit = (state_q == ST_EMIT) && status.out_free;
	end

endmodule
`default_nettype wire

### hdl/ncs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ncs_dp: point store, query buffer and distance pipeline
// Gather joints, copy points into the store, scan it through a
// read / square / accumulate / compare pipeline, hold the result.
// ----------------------------------------------------------------------------
module ncs_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ncs_pkg::ncs_cmd_t                   cmd,
	output ncs_pkg::ncs_status_t                     status,
	input  wire logic [ncs_pkg::S_DATA_BITS-1:0]     s_tdata,
	input  wire logic                                s_tlast,
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [ncs_pkg::M_DATA_BITS-1:0]     m_tdata,
	output logic                                     m_tuser
);
	import ncs_pkg::*;

	// Query buffer and gather position
	angle_t          qbuf_q [JOINTS];
	logic [PW-1:0]   pos_q;
	logic [PW-1:0]   qlen_q;

	// Store bookkeeping and walk counters
	logic [CW-1:0]   cnt_q;
	logic [AW-1:0]   wr_addr_q;
	logic [AW-1:0]   rd_addr_q;
	logic [IW-1:0]   pt_q;
	logic [JW-1:0]   j_q;
	logic            j_last;
	angle_t          qval;

	// Result of the marker item
	logic                  func_q;
	logic                  full_q;
	logic                  empty_q;
	logic [INDEX_BITS-1:0] ins_idx_q;

	// Scan pipeline
	logic                  valid_s1, end_s1, last_s1;
	logic [IW-1:0]         idx_s1;
	angle_t                q_s1;
	logic [ANGLE_BITS-1:0] rdata;
	logic signed [ANGLE_BITS:0]  diff;
	logic signed [SQW-1:0]       prod;
	logic                  valid_s2, end_s2, last_s2;
	logic [IW-1:0]         idx_s2;
	logic [SQW-1:0]        sq_s2;
	logic [SUMW-1:0]       sum;
	logic [DIST_BITS-1:0]  sum_sat;
	logic [DIST_BITS-1:0]  acc_q;
	logic                  tv_s3, last_s3;
	logic [IW-1:0]         idx_s3;
	logic [DIST_BITS-1:0]  tot_s3;
	logic                  first_q;
	logic [IW-1:0]         best_idx_q;
	logic [DIST_BITS-1:0]  best_d_q;

	// Output register
	logic                  out_valid_q;
	logic                  out_kind_q, out_found_q, out_full_q;
	logic [INDEX_BITS-1:0] out_idx_q;
	logic [DIST_BITS-1:0]  out_dist_q;

	assign j_last = (j_q == JW'(JOINTS - 1));
	assign qval   = (PW'(j_q) < qlen_q) ? qbuf_q[j_q] : '0;

	always_comb begin
		status.store_full  = (cnt_q == CW'(MAX_POINTS));
		status.store_empty = (cnt_q == '0);
		status.copy_last   = cmd.copy && j_last;
		status.scan_last   = cmd.scan && j_last && (CW'(pt_q) == cnt_q - CW'(1));
		status.scan_done   = tv_s3 && last_s3;
		status.out_free    = !out_valid_q || m_tready;
	end

	// Gather joints; excess joints are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			qlen_q <= '0;
		end else if (cmd.take) begin
			if (pos_q < PW'(JOINTS)) begin
				qbuf_q[pos_q[JW-1:0]] <= to_angle(s_tdata[IN_ANGLE_BITS-1:0]);
			end
			if (s_tlast) begin
				qlen_q <= (pos_q < PW'(JOINTS)) ? pos_q + PW'(1) : pos_q;
				pos_q  <= '0;
			end else if (pos_q < PW'(JOINTS)) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && s_tlast) begin
			func_q    <= s_tuser;
			full_q    <= status.store_full;
			empty_q   <= status.store_empty;
			ins_idx_q <= INDEX_BITS'(cnt_q);
		end
	end

	// Walk counters: between copies the write address sits at cnt_q * JOINTS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			wr_addr_q <= '0;
			rd_addr_q <= '0;
			pt_q      <= '0;
			j_q       <= '0;
		end else begin
			if (cmd.copy || cmd.scan) begin
				j_q <= j_last ? '0 : j_q + JW'(1);
			end
			if (cmd.copy) begin
				wr_addr_q <= wr_addr_q + AW'(1);
				if (j_last) cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.scan) begin
				if (status.scan_last) begin
					rd_addr_q <= '0;
					pt_q      <= '0;
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
					if (j_last) pt_q <= pt_q + IW'(1);
				end
			end
		end
	end

	ncs_ram #(
		.WIDTH (ANGLE_BITS),
		.DEPTH (MAX_POINTS * JOINTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.copy),
		.waddr (wr_addr_q),
		.wdata (qval),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	// Stage 1 tags travel alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			tv_s3    <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan;
			valid_s2 <= valid_s1;
			tv_s3    <= valid_s2 && end_s2;
		end
	end

	always_ff @(posedge clk) begin
		end_s1  <= j_last;
		last_s1 <= status.scan_last;
		idx_s1  <= pt_q;
		q_s1    <= qval;
	end

	// Stage 2: difference and square
	always_comb begin
		diff = (ANGLE_BITS + 1)'(signed'(rdata)) - (ANGLE_BITS + 1)'(q_s1);
		prod = diff * diff;
	end

	always_ff @(posedge clk) begin
		sq_s2   <= unsigned'(prod);
		end_s2  <= end_s1;
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
	end

	// Stage 3: saturating accumulate per point
	always_comb begin
		sum     = SUMW'(acc_q) + SUMW'(sq_s2);
		sum_sat = (sum > SUMW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= end_s2 ? '0 : sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		tot_s3  <= sum_sat;
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
	end

	// Stage 4: keep the strictly smaller distance, earliest index on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (tv_s3) begin
			first_q <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (tv_s3 && (first_q || (tot_s3 < best_d_q))) begin
			best_d_q   <= tot_s3;
			best_idx_q <= idx_s3;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (func_q == FUNC_INSERT) begin
				out_kind_q  <= KIND_ACK;
				out_found_q <= 1'b0;
				out_full_q  <= full_q;
				out_idx_q   <= full_q ? '0 : ins_idx_q;
				out_dist_q  <= '0;
			end else begin
				out_kind_q  <= KIND_ANSWER;
				out_found_q <= !empty_q;
				out_full_q  <= 1'b0;
				out_idx_q   <= empty_q ? '0 : INDEX_BITS'(best_idx_q);
				out_dist_q  <= empty_q ? '0 : best_d_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {out_dist_q, out_idx_q, out_full_q, out_found_q};

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || m_tready))
		else $error("result loaded over a pending transaction");
	a_copy_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy |-> !status.store_full)
		else $error("store written while full");
	a_scan_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !status.store_empty)
		else $error("scan issued on an empty store");
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.copy, cmd.scan, cmd.emit}))
		else $error("overlapping datapath commands");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count beyond store size");

endmodule
`default_nettype wire

### hdl/nearest_configuration_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_configuration_search: joint-space point store with nearest query
// Points stream in one joint per transaction; a completed point is either
// appended to the store or searched against it by squared distance.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                         tuser   tlast
//  s_       in   joint_angle[15:0]                          func    last_joint
//  m_       out  found, store_full, point_index[9:0],        kind    -
//                distance_squared[35:0]
//
//  A joint transaction without the marker leaves s_tready high.
//  After the marker, s_tready stays low until the result is loaded: an
//  insert first copies the point into the store, a full-store insert or
//  empty-store query goes straight to the result, and a query first
//  scans the store through the single read port of the point store (one
//  joint per cycle) and then drains the pipeline.
//  Reset clears the store count and the gather position; no clearing pass.
//  A result waiting on m_tready holds; new joints are still taken meanwhile.
//
module nearest_configuration_search (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: joint_angle[15:0]
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [ncs_pkg::S_DATA_BITS-1:0] s_tdata,
	input  wire logic                            s_tlast,
	// s_tuser: func
	input  wire logic                            s_tuser,
	// m_tdata: found[0], store_full[1], point_index[11:2],
	//          distance_squared[47:12]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [ncs_pkg::M_DATA_BITS-1:0] m_tdata,
	// m_tuser: kind
	output logic                                 m_tuser
);
	import ncs_pkg::*;

	ncs_cmd_t    cmd;
	ncs_status_t status;

	// Sequencer: decide copy, scan or direct answer at each marker
	ncs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: query buffer, store, distance pipeline, output register
	ncs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
